// ===== src/bpd_pkg.sv =====
// Shared types and constants for the binary packet deframer.
// No dependencies; imported by the parser and the top level.
`default_nettype none

package bpd_pkg;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_TYPE = 3'd1,
        PH_ADDR = 3'd2,
        PH_DATA = 3'd3,
        PH_CSHI = 3'd4,
        PH_CSLO = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_FOUND = 3'd0,
        ST_SHORT = 3'd1,
        ST_NOHDR = 3'd2,
        ST_TRUNC = 3'd3,
        ST_CSERR = 3'd4,
        ST_LONG  = 3'd5,
        ST_NONE  = 3'd6
    } status_t;

    // one report of the parser; burst marks a found packet with data to read out
    typedef struct packed {
        logic        valid;
        logic        burst;
        status_t     status;
        logic [7:0]  addr;
        logic [7:0]  ptype;
        logic [5:0]  len;
    } report_t;

    localparam logic [7:0]  HDR_S         = 8'h73;
    localparam logic [7:0]  HDR_N         = 8'h6E;
    localparam logic [7:0]  HDR_P         = 8'h70;
    localparam logic [15:0] HDR_SN        = {HDR_S, HDR_N};
    localparam logic [15:0] HDR_SUM       = {8'h00, HDR_S} + {8'h00, HDR_N} + {8'h00, HDR_P};
    localparam int          TYPE_HAS_DATA = 7;
    localparam int          TYPE_BATCH    = 6;
    localparam logic [5:0]  SINGLE_LEN    = 6'd4;
    localparam logic [2:0]  TAIL_MAX      = 3'd7;
    localparam logic [2:0]  TAIL_NONE_MAX = 3'd2;
    localparam logic [2:0]  TAIL_SHORT_MAX = 3'd6;

endpackage

`default_nettype wire

// ===== src/bpd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold read data when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/bpd_parser.sv =====
// Byte-wise packet parser: header hunt, field capture, checksum and buffer status.
// Depends on bpd_pkg; drives the write port of the data RAM.
`default_nettype none

module bpd_parser
    import bpd_pkg::*;
#(
    parameter int DATA_CAPACITY = 64,
    localparam int AW = $clog2(DATA_CAPACITY)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    rx_byte,
    input  wire logic          end_of_buffer,
    input  wire logic [7:0]    expected_address,
    output report_t            report,
    output logic               wr_en,
    output logic [AW-1:0]      wr_addr,
    output logic [7:0]         wr_data
);

    localparam logic [6:0] CAP = 7'(DATA_CAPACITY);

    phase_t      phase_reg, phase_next;
    logic [15:0] recent_reg, recent_next;
    logic [2:0]  tail_reg, tail_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  addr_reg, addr_next;
    logic [5:0]  len_reg, len_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  rsum_hi_reg, rsum_hi_next;
    logic        reported_reg, reported_next;

    logic [5:0]  cnt_inc;
    logic [15:0] rx_sum;

    always_comb
    begin
        phase_next    = phase_reg;
        recent_next   = recent_reg;
        tail_next     = tail_reg;
        type_next     = type_reg;
        addr_next     = addr_reg;
        len_next      = len_reg;
        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        rsum_hi_next  = rsum_hi_reg;
        reported_next = reported_reg;
        report        = '0;
        report.status = ST_FOUND;
        wr_en         = 1'b0;
        wr_addr       = cnt_reg[AW-1:0];
        wr_data       = rx_byte;
        cnt_inc       = cnt_reg + 6'd1;
        rx_sum        = {rsum_hi_reg, rx_byte};

        if (accept && !reported_reg)
        begin
            if (tail_reg < TAIL_MAX)
            begin
                tail_next = tail_reg + 3'd1;
            end
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == HDR_P && recent_reg == HDR_SN)
                    begin
                        phase_next  = PH_TYPE;
                        sum_next    = HDR_SUM;
                        recent_next = '0;
                    end
                    else
                    begin
                        recent_next = {recent_reg[7:0], rx_byte};
                    end
                end
                PH_TYPE:
                begin
                    type_next = rx_byte;
                    sum_next  = sum_reg + {8'h00, rx_byte};
                    if (rx_byte[TYPE_HAS_DATA])
                    begin
                        len_next = rx_byte[TYPE_BATCH] ? {rx_byte[5:2], 2'b00} : SINGLE_LEN;
                    end
                    else
                    begin
                        len_next = '0;
                    end
                    phase_next = PH_ADDR;
                end
                PH_ADDR:
                begin
                    addr_next  = rx_byte;
                    sum_next   = sum_reg + {8'h00, rx_byte};
                    cnt_next   = '0;
                    phase_next = (len_reg != '0) ? PH_DATA : PH_CSHI;
                end
                PH_DATA:
                begin
                    wr_en    = ({1'b0, cnt_reg} < CAP);
                    sum_next = sum_reg + {8'h00, rx_byte};
                    cnt_next = cnt_inc;
                    if (cnt_inc >= len_reg)
                    begin
                        phase_next = PH_CSHI;
                    end
                end
                PH_CSHI:
                begin
                    rsum_hi_next = rx_byte;
                    phase_next   = PH_CSLO;
                end
                default:
                begin
                    if ({1'b0, len_reg} > CAP)
                    begin
                        report.valid  = 1'b1;
                        report.status = ST_LONG;
                        reported_next = 1'b1;
                    end
                    else if (rx_sum != sum_reg)
                    begin
                        report.valid  = 1'b1;
                        report.status = ST_CSERR;
                        reported_next = 1'b1;
                    end
                    else if (addr_reg == expected_address)
                    begin
                        report.valid  = 1'b1;
                        report.burst  = (len_reg != '0);
                        report.status = ST_FOUND;
                        reported_next = 1'b1;
                    end
                    else
                    begin
                        // valid packet for another address: resume the hunt
                        phase_next  = PH_HUNT;
                        recent_next = '0;
                        tail_next   = '0;
                    end
                end
            endcase

            if (end_of_buffer && !reported_next)
            begin
                report.valid = 1'b1;
                if (tail_next <= TAIL_NONE_MAX)
                begin
                    report.status = ST_NONE;
                end
                else if (tail_next <= TAIL_SHORT_MAX)
                begin
                    report.status = ST_SHORT;
                end
                else if (phase_next != PH_HUNT)
                begin
                    report.status = ST_TRUNC;
                end
                else
                begin
                    report.status = ST_NOHDR;
                end
            end
            report.addr  = addr_next;
            report.ptype = type_next;
            report.len   = len_next;
        end

        // new buffer after the end mark
        if (accept && end_of_buffer)
        begin
            phase_next    = PH_HUNT;
            recent_next   = '0;
            tail_next     = '0;
            type_next     = '0;
            addr_next     = '0;
            len_next      = '0;
            cnt_next      = '0;
            sum_next      = '0;
            rsum_hi_next  = '0;
            reported_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            recent_reg   <= '0;
            tail_reg     <= '0;
            type_reg     <= '0;
            addr_reg     <= '0;
            len_reg      <= '0;
            cnt_reg      <= '0;
            sum_reg      <= '0;
            rsum_hi_reg  <= '0;
            reported_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            recent_reg   <= recent_next;
            tail_reg     <= tail_next;
            type_reg     <= type_next;
            addr_reg     <= addr_next;
            len_reg      <= len_next;
            cnt_reg      <= cnt_next;
            sum_reg      <= sum_next;
            rsum_hi_reg  <= rsum_hi_next;
            reported_reg <= reported_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/binary_packet_deframer_sum16_core.sv =====
// Top level of the binary packet deframer with 16-bit additive checksum.
// Depends on bpd_pkg, bpd_parser and bpd_ram (data store and readout).
//
// Channel   Direction  Transfer on              Contents
// s_axis    in         s_axis_tvalid & tready   received byte, tlast = end of buffer
// m_axis    out        m_axis_tvalid & tready   report item, tlast = last item
// cfg       in         cfg_valid & cfg_ready    expected address (always ready)
//
// One byte is taken per cycle while no readout runs and the output can take it;
// a single-item report goes to the output register in the cycle of its byte. A
// found packet's N data bytes are read out of the RAM at one item per cycle unless
// the output stalls, each through the readout sequencer, RAM read stage, output register.
// Input is held off until the last item has left the RAM read stage.
// Reset clears all control state; the data RAM is not cleared.
// Output stalls back-pressure input only when the output register is full.
`default_nettype none

module binary_packet_deframer_sum16_core
    import bpd_pkg::*;
#(
    parameter int DATA_CAPACITY = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [7:0] address, [15:8] packet_type,
                                             // [21:16] payload_len, [29:22] data_byte,
                                             // [35:30] byte_index, [39:36] zero
    output logic [2:0]       m_axis_tuser,   // [2:0] status
    output logic             m_axis_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data
);

    localparam int AW = $clog2(DATA_CAPACITY);

    logic [7:0]  exp_addr_reg;

    report_t     report;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]  wr_data;
    logic [7:0]  rd_data;

    logic        in_accept;
    logic        in_load;
    logic        issue;
    logic        s1_adv;
    logic [5:0]  rd_cnt_inc;
    logic        rd_is_last;

    // readout sequencer
    logic        rd_active_reg;
    logic [5:0]  rd_cnt_reg;
    logic [5:0]  rd_len_reg;
    logic [7:0]  rd_addr_reg;
    logic [7:0]  rd_type_reg;

    // RAM read stage
    logic        s1_valid_reg;
    logic [5:0]  s1_idx_reg;
    logic        s1_last_reg;

    // output register
    logic        out_valid_reg;
    status_t     out_status_reg;
    logic [7:0]  out_addr_reg;
    logic [7:0]  out_type_reg;
    logic [5:0]  out_len_reg;
    logic [7:0]  out_data_reg;
    logic [5:0]  out_idx_reg;
    logic        out_last_reg;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !rd_active_reg && !s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_load       = report.valid && !report.burst;
    assign s1_adv        = s1_valid_reg && (!out_valid_reg || m_axis_tready);
    assign issue         = rd_active_reg && (!s1_valid_reg || s1_adv);
    assign rd_cnt_inc    = rd_cnt_reg + 6'd1;
    assign rd_is_last    = (rd_cnt_inc == rd_len_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_addr_reg <= '0;
        end
        else if (cfg_valid)
        begin
            exp_addr_reg <= cfg_data;
        end
    end

    bpd_parser #(
        .DATA_CAPACITY(DATA_CAPACITY)
    ) u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (in_accept),
        .rx_byte          (s_axis_tdata),
        .end_of_buffer    (s_axis_tlast),
        .expected_address (exp_addr_reg),
        .report           (report),
        .wr_en            (wr_en),
        .wr_addr          (wr_addr),
        .wr_data          (wr_data)
    );

    bpd_ram #(
        .WIDTH(8),
        .DEPTH(DATA_CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (rd_cnt_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_active_reg <= 1'b0;
            rd_cnt_reg    <= '0;
        end
        else if (report.valid && report.burst)
        begin
            rd_active_reg <= 1'b1;
            rd_cnt_reg    <= '0;
        end
        else if (issue)
        begin
            rd_cnt_reg <= rd_cnt_inc;
            if (rd_is_last)
            begin
                rd_active_reg <= 1'b0;
            end
        end
    end

    // hold the packet fields for the whole readout
    always_ff @(posedge clk)
    begin
        if (report.valid && report.burst)
        begin
            rd_len_reg  <= report.len;
            rd_addr_reg <= report.addr;
            rd_type_reg <= report.ptype;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (issue)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_idx_reg  <= rd_cnt_reg;
            s1_last_reg <= rd_is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_load || s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            out_status_reg <= report.status;
            out_addr_reg   <= report.addr;
            out_type_reg   <= report.ptype;
            out_len_reg    <= report.len;
            out_data_reg   <= '0;
            out_idx_reg    <= '0;
            out_last_reg   <= 1'b1;
        end
        else if (s1_adv)
        begin
            out_status_reg <= ST_FOUND;
            out_addr_reg   <= rd_addr_reg;
            out_type_reg   <= rd_type_reg;
            out_len_reg    <= rd_len_reg;
            out_data_reg   <= rd_data;
            out_idx_reg    <= s1_idx_reg;
            out_last_reg   <= s1_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {4'h0, out_idx_reg, out_data_reg, out_len_reg,
                            out_type_reg, out_addr_reg};

endmodule

`default_nettype wire

// ===== tb/binary_packet_deframer_sum16_core_tb.sv =====
// Self-checking testbench for binary_packet_deframer_sum16_core: byte stream in, reports out.
// Uses bpd_pkg for the status and phase codes and the header constants; needs only the RTL.
module binary_packet_deframer_sum16_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpd_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE       = 12;
    localparam int FINAL_SETTLE = 80;

    typedef struct {
        logic [7:0] data;
        logic       eob;
    } rx_item_t;

    typedef struct {
        status_t    status;
        logic [7:0] address;
        logic [7:0] ptype;
        logic [5:0] len;
        logic [7:0] data;
        logic [5:0] index;
        logic       last;
    } deframe_item_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = 8'h00;

    rx_item_t      rx_backlog[$];
    deframe_item_t report_queue[$];
    logic [7:0]    frame_bytes[$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_req   = 1'b0;
    logic        hold_req_q = 1'b0;
    int unsigned hold_left  = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;

    // deframer shadow state
    logic [7:0] match_addr = 8'h00;
    phase_t     hunt_state;
    logic [15:0] last_two;
    logic [2:0]  tail_cnt;
    logic [7:0]  type_q;
    logic [7:0]  addr_q;
    logic [5:0]  len_q;
    logic [5:0]  data_cnt;
    logic [15:0] sum_acc;
    logic [15:0] sum_rx;
    logic        done_flag;
    logic [7:0]  store [CAPACITY];

    binary_packet_deframer_sum16_core #(
        .DATA_CAPACITY(CAPACITY)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic restart_buffer();
        hunt_state = PH_HUNT;
        last_two   = 16'h0000;
        tail_cnt   = 3'd0;
        type_q     = 8'h00;
        addr_q     = 8'h00;
        len_q      = 6'd0;
        data_cnt   = 6'd0;
        sum_acc    = 16'h0000;
        sum_rx     = 16'h0000;
        done_flag  = 1'b0;
    endtask

    task automatic add_report(input status_t st, input logic [7:0] d, input logic [5:0] idx,
                              input logic lst);
        deframe_item_t it;
        it.status  = st;
        it.address = addr_q;
        it.ptype   = type_q;
        it.len     = len_q;
        it.data    = d;
        it.index   = idx;
        it.last    = lst;
        report_queue.push_back(it);
    endtask

    task automatic deframe_byte(input logic [7:0] b, input logic eob);
        status_t st;
        int      i;
        if (!done_flag)
        begin
            if (tail_cnt < TAIL_MAX)
                tail_cnt = tail_cnt + 3'd1;
            case (hunt_state)
                PH_HUNT:
                begin
                    if (b == HDR_P && last_two == HDR_SN)
                    begin
                        hunt_state = PH_TYPE;
                        sum_acc    = HDR_SUM;
                        last_two   = 16'h0000;
                    end
                    else
                        last_two = {last_two[7:0], b};
                end
                PH_TYPE:
                begin
                    type_q  = b;
                    sum_acc = sum_acc + {8'h00, b};
                    if (b[TYPE_HAS_DATA])
                        len_q = b[TYPE_BATCH] ? {b[5:2], 2'b00} : SINGLE_LEN;
                    else
                        len_q = 6'd0;
                    hunt_state = PH_ADDR;
                end
                PH_ADDR:
                begin
                    addr_q     = b;
                    sum_acc    = sum_acc + {8'h00, b};
                    data_cnt   = 6'd0;
                    hunt_state = (len_q != 6'd0) ? PH_DATA : PH_CSHI;
                end
                PH_DATA:
                begin
                    if (int'(data_cnt) < CAPACITY)
                        store[data_cnt] = b;
                    sum_acc  = sum_acc + {8'h00, b};
                    data_cnt = data_cnt + 6'd1;
                    if (data_cnt >= len_q)
                        hunt_state = PH_CSHI;
                end
                PH_CSHI:
                begin
                    sum_rx     = {b, 8'h00};
                    hunt_state = PH_CSLO;
                end
                default:
                begin
                    sum_rx[7:0] = b;
                    if (int'(len_q) > CAPACITY)
                    begin
                        add_report(ST_LONG, 8'h00, 6'd0, 1'b1);
                        done_flag = 1'b1;
                    end
                    else if (sum_rx != sum_acc)
                    begin
                        add_report(ST_CSERR, 8'h00, 6'd0, 1'b1);
                        done_flag = 1'b1;
                    end
                    else if (addr_q == match_addr)
                    begin
                        if (len_q == 6'd0)
                            add_report(ST_FOUND, 8'h00, 6'd0, 1'b1);
                        else
                            for (i = 0; i < int'(len_q) && i < CAPACITY; i++)
                                add_report(ST_FOUND, store[i], i[5:0], i + 1 == int'(len_q));
                        done_flag = 1'b1;
                    end
                    else
                    begin
                        // skip a valid packet for another address and resume the hunt
                        hunt_state = PH_HUNT;
                        last_two   = 16'h0000;
                        tail_cnt   = 3'd0;
                    end
                end
            endcase

            if (eob && !done_flag)
            begin
                if (tail_cnt <= TAIL_NONE_MAX)
                    st = ST_NONE;
                else if (tail_cnt <= TAIL_SHORT_MAX)
                    st = ST_SHORT;
                else if (hunt_state != PH_HUNT)
                    st = ST_TRUNC;
                else
                    st = ST_NOHDR;
                add_report(st, 8'h00, 6'd0, 1'b1);
                done_flag = 1'b1;
            end
        end
        if (eob)
            restart_buffer();
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // byte driver: hold each transfer until accepted, predict on acceptance
    always @(posedge clk)
    begin : byte_driver
        rx_item_t nxt;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                deframe_byte(s_axis_tdata, s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (rx_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = rx_backlog.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.data;
                    s_axis_tlast  <= nxt.eob;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // report monitor and output back-pressure
    always @(posedge clk)
    begin : report_check
        deframe_item_t want;
        hold_req_q <= hold_req;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (report_queue.size() == 0)
            begin
                $display("%0t: unexpected report: expected none, got status %0d tdata 0x%0h",
                         $time, m_axis_tuser, m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = report_queue.pop_front();
                check_field("status", want.status, m_axis_tuser);
                check_field("address", want.address, m_axis_tdata[7:0]);
                check_field("packet_type", want.ptype, m_axis_tdata[15:8]);
                check_field("payload_len", want.len, m_axis_tdata[21:16]);
                check_field("data_byte", want.data, m_axis_tdata[29:22]);
                check_field("byte_index", want.index, m_axis_tdata[35:30]);
                check_field("last", want.last, m_axis_tlast);
            end
        end
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_req && !hold_req_q)
        begin
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        @(posedge rst_n);
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("binary_packet_deframer_sum16_core regression: fail");
        $finish;
    end

    task automatic append_noise(input int count);
        repeat (count)
            frame_bytes.push_back(8'($urandom_range(255)));
    endtask

    task automatic append_packet(input logic [7:0] addr, input bit bad_sum);
        logic [7:0]  t;
        logic [7:0]  d;
        logic [15:0] sum;
        int          n;
        t = 8'($urandom_range(255));
        case ($urandom_range(3))
            0: t[7] = 1'b0;
            1: t[7:6] = 2'b10;
            default:
            begin
                t[7:6] = 2'b11;
                t[5:2] = 4'($urandom_range(3));
            end
        endcase
        n = !t[7] ? 0 : (!t[6] ? 4 : int'(t[5:2]) * 4);
        frame_bytes.push_back(HDR_S);
        frame_bytes.push_back(HDR_N);
        frame_bytes.push_back(HDR_P);
        frame_bytes.push_back(t);
        frame_bytes.push_back(addr);
        sum = HDR_SUM + {8'h00, t} + {8'h00, addr};
        repeat (n)
        begin
            d = 8'($urandom_range(255));
            frame_bytes.push_back(d);
            sum = sum + {8'h00, d};
        end
        if (bad_sum)
            sum = sum ^ (16'h0001 << $urandom_range(15));
        frame_bytes.push_back(sum[15:8]);
        frame_bytes.push_back(sum[7:0]);
    endtask

    function automatic logic [7:0] other_addr();
        logic [7:0] a;
        do
            a = 8'($urandom_range(255));
        while (a == match_addr);
        return a;
    endfunction

    // move the assembled buffer to the driver, end mark on its last byte
    task automatic flush_buffer();
        int i;
        for (i = 0; i < frame_bytes.size(); i++)
            rx_backlog.push_back('{data: frame_bytes[i], eob: (i == frame_bytes.size() - 1)});
        frame_bytes.delete();
    endtask

    task automatic queue_random_buffer();
        int k;
        frame_bytes.delete();
        case ($urandom_range(9))
            0, 1, 2, 3:
            begin
                append_noise($urandom_range(3));
                append_packet(match_addr, 1'b0);
                append_noise($urandom_range(3));
            end
            4:
            begin
                append_noise($urandom_range(2));
                append_packet($urandom_range(1) ? match_addr : other_addr(), 1'b1);
                append_noise($urandom_range(2));
            end
            5, 6:
            begin
                repeat ($urandom_range(1, 2))
                    append_packet(other_addr(), 1'b0);
                append_noise($urandom_range(8));
            end
            7:
            begin
                // cut a packet short before its checksum completes
                append_noise($urandom_range(8));
                append_packet(8'($urandom_range(255)), 1'b0);
                k = $urandom_range(1, 4);
                repeat (k)
                    void'(frame_bytes.pop_back());
            end
            8: append_noise($urandom_range(1, 12));
            default:
            begin
                append_packet(other_addr(), 1'b0);
                append_packet(match_addr, 1'b0);
            end
        endcase
        flush_buffer();
    endtask

    task automatic write_cfg(input logic [7:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid  <= 1'b0;
        match_addr = v;
    endtask

    // wait until the sender is empty and every report is in, then let the block settle
    task automatic drain();
        while (rx_backlog.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (report_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_phase(input logic [7:0] addr, input int unsigned send_pct,
                             input int unsigned recv_pct, input int nbuf, input bit pressure);
        write_cfg(addr);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (pressure)
            hold_req <= 1'b1;
        repeat (nbuf)
            queue_random_buffer();
        if (pressure)
        begin
            repeat (nbuf)
                queue_random_buffer();
        end
        drain();
        hold_req <= 1'b0;
    endtask

    initial
    begin
        restart_buffer();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: found without data at the reset address
        frame_bytes = '{HDR_S, HDR_N, HDR_P, 8'h00, 8'h00, HDR_SUM[15:8], HDR_SUM[7:0]};
        flush_buffer();
        // none matched
        frame_bytes = '{8'hFF};
        flush_buffer();
        // short tail
        frame_bytes = '{8'h55, 8'hAA, 8'h00};
        flush_buffer();
        // partial header at the end: no header
        frame_bytes = '{8'h00, 8'h80, 8'hFF, 8'h01, 8'h7F, HDR_S, HDR_N};
        flush_buffer();
        // truncated inside the data
        frame_bytes = '{HDR_S, HDR_N, HDR_P, 8'hC4, 8'h00, 8'h11, 8'h22};
        flush_buffer();
        drain();

        run_phase(8'hFF, 0, 0, 1, 1'b0);
        run_phase(8'($urandom_range(255)), 76, 0, 1, 1'b0);
        run_phase(8'h00, 0, 76, 1, 1'b0);
        run_phase(HDR_S, 6, 6, 1, 1'b0);
        run_phase(8'($urandom_range(255)), 0, 0, 1, 1'b1);

        repeat (FINAL_SETTLE) @(posedge clk);
        if (mismatch_count == 0 && report_queue.size() == 0)
            $display("binary_packet_deframer_sum16_core regression: pass");
        else
            $display("binary_packet_deframer_sum16_core regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bpd_pkg.sv
src/bpd_ram.sv
src/bpd_parser.sv
src/binary_packet_deframer_sum16_core.sv
tb/binary_packet_deframer_sum16_core_tb.sv
